@@ src/wmv_pkg.sv @@
package wmv_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int MEAN_W      = 32;
	localparam int SUM_W       = 62;
	localparam int VAR_W       = 47;
	localparam int COUNT_OUT_W = 24;
	localparam int DVD_W       = 47;
	localparam int ITER_W      = 6;
	localparam int STEP_W      = 4;
	localparam int FRAC_W      = 16;
	localparam int SUM_FRAC_W  = 8;
	localparam int TERM_SHIFT  = 24;
	localparam int VAR_SHIFT   = VAR_W - SUM_FRAC_W;
	localparam int MEAN_QUO_W  = 32;

	localparam logic [ITER_W-1:0] MEAN_ITERS = ITER_W'(MEAN_QUO_W);
	localparam logic [ITER_W-1:0] VAR_ITERS  = ITER_W'(DVD_W);

	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_PREP,
		OP_DIV,
		OP_MEAN,
		OP_MUL,
		OP_SUM,
		OP_VPREP,
		OP_VFIN,
		OP_OUT
	} uop_t;

	typedef enum logic [2:0] {
		CD_NEXT,
		CD_JUMP,
		CD_HOLD_IN,
		CD_FULL,
		CD_LOOP,
		CD_TRIVIAL,
		CD_HOLD_OUT
	} cond_t;

	typedef struct packed {
		uop_t  op;
		cond_t cond;
		step_t target;
	} uword_t;

	localparam step_t ST_ACCEPT = 4'd0;
	localparam step_t ST_PREP   = 4'd1;
	localparam step_t ST_MDIV   = 4'd2;
	localparam step_t ST_MEAN   = 4'd3;
	localparam step_t ST_MUL    = 4'd4;
	localparam step_t ST_SUM    = 4'd5;
	localparam step_t ST_VPREP  = 4'd6;
	localparam step_t ST_VDIV   = 4'd7;
	localparam step_t ST_VFIN   = 4'd8;
	localparam step_t ST_OUT    = 4'd9;

	// microprogram: one control word per step
	function automatic uword_t ucode(input step_t pc);
		uword_t w;
		unique case (pc)
			ST_ACCEPT: w = '{OP_ACCEPT, CD_HOLD_IN,  ST_ACCEPT};
			ST_PREP:   w = '{OP_PREP,   CD_FULL,     ST_VPREP};
			ST_MDIV:   w = '{OP_DIV,    CD_LOOP,     ST_MDIV};
			ST_MEAN:   w = '{OP_MEAN,   CD_NEXT,     ST_ACCEPT};
			ST_MUL:    w = '{OP_MUL,    CD_NEXT,     ST_ACCEPT};
			ST_SUM:    w = '{OP_SUM,    CD_NEXT,     ST_ACCEPT};
			ST_VPREP:  w = '{OP_VPREP,  CD_TRIVIAL,  ST_OUT};
			ST_VDIV:   w = '{OP_DIV,    CD_LOOP,     ST_VDIV};
			ST_VFIN:   w = '{OP_VFIN,   CD_NEXT,     ST_ACCEPT};
			ST_OUT:    w = '{OP_OUT,    CD_HOLD_OUT, ST_ACCEPT};
			default:   w = '{OP_NONE,   CD_JUMP,     ST_ACCEPT};
		endcase
		return w;
	endfunction

endpackage

@@ src/wmv_div.sv @@
module wmv_div #(
	parameter int CW = 24
) (
	input  logic                    clk,
	input  logic                    load,
	input  logic                    run,
	input  logic [CW-1:0]           rem_init,
	input  logic [wmv_pkg::DVD_W-1:0] dvd_init,
	input  logic [CW-1:0]           dvs,
	output logic [wmv_pkg::DVD_W-1:0] quo
);
	import wmv_pkg::*;

	logic [CW-1:0]    rem_q;
	logic [CW-1:0]    dvs_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVD_W-1:0] quo_q;
	logic [CW:0]      trial;
	logic             fits;

	// partial remainder stays below the divisor, so a successful trial fits in CW bits
	assign trial = {rem_q, dvd_q[DVD_W-1]} - {1'b0, dvs_q};
	assign fits  = !trial[CW];

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= rem_init;
			dvs_q <= dvs;
			dvd_q <= dvd_init;
		end else if (run) begin
			rem_q <= fits ? trial[CW-1:0] : {rem_q[CW-2:0], dvd_q[DVD_W-1]};
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign quo = quo_q;

endmodule

@@ src/welford_mean_variance.sv @@
// Welford running statistics over signed 16-bit samples. Each input beat carries one sample
// and yields one output beat with the mean (signed Q16.16), the sample variance (unsigned
// Q31.16, saturating, zero until two samples are in) and the count. A set restart bit clears
// the statistics before the sample is taken; once the count is full, samples are dropped and
// the beat is flagged saturated. A small microprogram drives one shared shift-subtract
// divider that yields one quotient bit per cycle. A sample runs the mean division and then the
// variance division; a dropped sample skips the mean update and runs only the variance
// division. When no variance division is needed (count of one, or a variance that saturates)
// it is skipped. One sample is in flight at a time; the next input beat is taken once the
// result has moved to the output register.
module welford_mean_variance #(
	parameter int COUNT_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [wmv_pkg::SAMPLE_W-1:0]  sample,
	input  logic                                 restart,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [wmv_pkg::MEAN_W-1:0]    mean_out,
	output logic [wmv_pkg::VAR_W-1:0]            variance_out,
	output logic [wmv_pkg::COUNT_OUT_W-1:0]      count_out,
	output logic                                 saturated
);
	import wmv_pkg::*;

	localparam int CW   = COUNT_BITS;
	localparam int HIW  = (CW > SUM_W - VAR_SHIFT) ? CW : SUM_W - VAR_SHIFT;
	localparam int COW  = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;
	localparam int CMPW = SUM_W + 10;
	localparam int DW   = MEAN_W + 1;

	function automatic logic [MEAN_W-1:0] mag(input logic [DW-1:0] v);
		logic [DW-1:0] n;
		n = -v;
		return v[DW-1] ? n[MEAN_W-1:0] : v[MEAN_W-1:0];
	endfunction

	// sequencer
	step_t              pc_q;
	step_t              pc_nxt;
	uword_t             uw;
	logic [ITER_W-1:0]  iter_q;

	// statistics
	logic [CW-1:0]      count_q;
	logic [MEAN_W-1:0]  mean_q;
	logic [SUM_W-1:0]   sum_q;

	// working registers
	logic [SAMPLE_W-1:0] sample_q;
	logic [DW-1:0]       delta_q;
	logic [DW-1:0]       resid_q;
	logic [2*MEAN_W-1:0] prod_q;
	logic                neg_q;
	logic                sat_q;
	logic [VAR_W-1:0]    var_q;

	// output register
	logic                out_valid_q;
	logic [MEAN_W-1:0]   mean_out_q;
	logic [VAR_W-1:0]    var_out_q;
	logic [COUNT_OUT_W-1:0] count_out_q;
	logic                sat_out_q;

	logic               in_beat;
	logic               out_busy;
	logic               full;
	logic               trivial;
	logic               few;
	logic               var_big;
	logic [DW-1:0]      xq;
	logic [DW-1:0]      mean_ext;
	logic [DW-1:0]      delta_now;
	logic [DW-1:0]      quo_signed;
	logic [DW-1:0]      new_mean;
	logic [MEAN_W-1:0]  qmag;
	logic [CW-1:0]      cnt_inc;
	logic [CW-1:0]      cnt_dec;
	logic [HIW-1:0]     sum_hi;
	logic [COW-1:0]     count_ext;
	logic [SUM_W:0]     sum_add;
	logic [2*MEAN_W-TERM_SHIFT-1:0] term;

	logic               div_load;
	logic               div_run;
	logic [CW-1:0]      div_rem;
	logic [DVD_W-1:0]   div_dvd;
	logic [CW-1:0]      div_dvs;
	logic [DVD_W-1:0]   div_quo;

	assign uw       = ucode(pc_q);
	assign in_stall = (pc_q != ST_ACCEPT);
	assign in_beat  = in_valid && !in_stall;
	assign out_busy = out_valid_q && out_stall;

	assign full     = (count_q == {CW{1'b1}});
	assign cnt_inc  = count_q + 1'b1;
	assign cnt_dec  = count_q - 1'b1;
	assign few      = (count_q[CW-1:1] == '0);
	// quotient would not fit the variance output
	assign var_big  = CMPW'(sum_q) >= CMPW'({cnt_dec, {VAR_SHIFT{1'b0}}});
	assign trivial  = few || var_big;

	assign xq        = {sample_q[SAMPLE_W-1], sample_q, {FRAC_W{1'b0}}};
	assign mean_ext  = {mean_q[MEAN_W-1], mean_q};
	assign delta_now = xq - mean_ext;
	assign qmag      = div_quo[MEAN_W-1:0];
	assign quo_signed = delta_q[DW-1] ? -{1'b0, qmag} : {1'b0, qmag};
	// the new mean lies between the old mean and the sample, so it always fits
	assign new_mean  = mean_ext + quo_signed;

	assign term    = neg_q ? '0 : prod_q[2*MEAN_W-1:TERM_SHIFT];
	assign sum_add = {1'b0, sum_q} + (SUM_W+1)'(term);

	assign sum_hi    = HIW'(sum_q[SUM_W-1:VAR_SHIFT]);
	assign count_ext = COW'(count_q);

	assign div_load = (uw.op == OP_PREP) || (uw.op == OP_VPREP);
	assign div_run  = (uw.op == OP_DIV);
	assign div_rem  = (uw.op == OP_PREP) ? '0 : sum_hi[CW-1:0];
	assign div_dvs  = (uw.op == OP_PREP) ? cnt_inc : cnt_dec;
	assign div_dvd  = (uw.op == OP_PREP) ?
		{mag(delta_now), {(DVD_W-MEAN_W){1'b0}}} :
		{sum_q[VAR_SHIFT-1:0], {SUM_FRAC_W{1'b0}}};

	wmv_div #(
		.CW (CW)
	) u_div (
		.clk      (clk),
		.load     (div_load),
		.run      (div_run),
		.rem_init (div_rem),
		.dvd_init (div_dvd),
		.dvs      (div_dvs),
		.quo      (div_quo)
	);

	always_comb begin
		pc_nxt = pc_q + 1'b1;
		unique case (uw.cond)
			CD_NEXT:     pc_nxt = pc_q + 1'b1;
			CD_JUMP:     pc_nxt = uw.target;
			CD_HOLD_IN:  pc_nxt = in_valid ? pc_q + 1'b1 : pc_q;
			CD_FULL:     pc_nxt = full ? uw.target : pc_q + 1'b1;
			CD_LOOP:     pc_nxt = (iter_q != ITER_W'(1)) ? uw.target : pc_q + 1'b1;
			CD_TRIVIAL:  pc_nxt = trivial ? uw.target : pc_q + 1'b1;
			CD_HOLD_OUT: pc_nxt = out_busy ? pc_q : uw.target;
			default:     pc_nxt = ST_ACCEPT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= ST_ACCEPT;
			iter_q      <= '0;
			count_q     <= '0;
			mean_q      <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_nxt;
			if (uw.op == OP_OUT && !out_busy) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (uw.op)
				OP_ACCEPT: begin
					if (in_beat && restart) begin
						count_q <= '0;
						mean_q  <= '0;
						sum_q   <= '0;
					end
				end
				OP_PREP: begin
					iter_q <= MEAN_ITERS;
					if (!full) begin
						count_q <= cnt_inc;
					end
				end
				OP_DIV:   iter_q <= iter_q - 1'b1;
				OP_MEAN:  mean_q <= new_mean[MEAN_W-1:0];
				OP_SUM:   sum_q  <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
				OP_VPREP: iter_q <= VAR_ITERS;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (uw.op)
			OP_ACCEPT: begin
				if (in_beat) begin
					sample_q <= sample;
				end
			end
			OP_PREP: begin
				sat_q   <= full;
				delta_q <= delta_now;
			end
			OP_MEAN:  resid_q <= xq - new_mean;
			OP_MUL: begin
				prod_q <= mag(delta_q) * mag(resid_q);
				neg_q  <= delta_q[DW-1] != resid_q[DW-1];
			end
			OP_VPREP: begin
				if (few) begin
					var_q <= '0;
				end else if (var_big) begin
					var_q <= {VAR_W{1'b1}};
				end
			end
			OP_VFIN:  var_q <= div_quo;
			OP_OUT: begin
				if (!out_busy) begin
					mean_out_q  <= mean_q;
					var_out_q   <= var_q;
					count_out_q <= count_ext[COUNT_OUT_W-1:0];
					sat_out_q   <= sat_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign mean_out     = mean_out_q;
	assign variance_out = var_out_q;
	assign count_out    = count_out_q;
	assign saturated    = sat_out_q;

endmodule

@@ sim/welford_mean_variance_tb.sv @@
`timescale 1ns / 1ps

module welford_mean_variance_tb;
	import wmv_pkg::*;

	// narrow counter so that the full count is reachable in a short run
	localparam int CNT_BITS   = 8;
	localparam int VAR_UP     = FRAC_W - SUM_FRAC_W;
	localparam int RAND_ITEMS = 1950;
	localparam int BLK_CYC    = 90;
	localparam int MAX_GAP    = 120;
	localparam int MAX_STALL  = 40;
	localparam int DRAIN_CYC  = 200;

	localparam logic [CNT_BITS-1:0] CNT_FULL = {CNT_BITS{1'b1}};
	localparam longint unsigned SUM_MAX = (64'd1 << SUM_W) - 64'd1;
	localparam longint unsigned VAR_MAX = (64'd1 << VAR_W) - 64'd1;

	typedef struct {
		logic signed [SAMPLE_W-1:0] value;
		logic                       restart;
		logic                       drain;
	} sample_item_t;

	typedef struct {
		logic signed [MEAN_W-1:0] mean;
		logic [VAR_W-1:0]         variance;
		logic [COUNT_OUT_W-1:0]   count;
		logic                     sat;
	} stats_t;

	logic                        clk;
	logic                        arst_n       = 1'b0;
	logic                        in_valid     = 1'b0;
	logic                        in_stall;
	logic signed [SAMPLE_W-1:0]  sample       = '0;
	logic                        restart      = 1'b0;
	logic                        out_valid;
	logic                        out_stall    = 1'b0;
	logic signed [MEAN_W-1:0]    mean_out;
	logic [VAR_W-1:0]            variance_out;
	logic [COUNT_OUT_W-1:0]      count_out;
	logic                        saturated;

	sample_item_t sample_q[$];
	stats_t       stats_q[$];

	// tracked statistics of the block
	logic [CNT_BITS-1:0]      st_count = '0;
	logic signed [MEAN_W-1:0] st_mean  = '0;
	logic [SUM_W-1:0]         st_sum   = '0;

	int     n_sent    = 0;
	int     n_taken   = 0;
	int     n_results = 0;
	int     n_err     = 0;
	longint cyc       = 0;
	longint cyc_limit = 64'h7fff_ffff_ffff_ffff;

	// fill-side bookkeeping: samples that the block will really take
	int shadow_cnt = 0;
	int n_real     = 0;

	int gap_left   = 0;
	int burst_left = 0;
	int rx_left    = 0;

	welford_mean_variance #(
		.COUNT_BITS(CNT_BITS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample      (sample),
		.restart     (restart),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.mean_out    (mean_out),
		.variance_out(variance_out),
		.count_out   (count_out),
		.saturated   (saturated)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic stats_t welford_update(input logic signed [SAMPLE_W-1:0] smp,
			input logic rst);
		stats_t          r;
		longint          xq, dlt, nm, res, cnt_l, mean_l;
		longint unsigned ma, mb, prod, term, room, sum_l, d, q, rm, vq;
		r.sat = 1'b0;
		if (rst) begin
			st_count = '0;
			st_mean  = '0;
			st_sum   = '0;
		end
		if (st_count == CNT_FULL) begin
			r.sat = 1'b1;
		end else begin
			st_count = st_count + 1'b1;
			cnt_l  = st_count;
			mean_l = st_mean;
			xq  = longint'(smp) * 65536;
			dlt = xq - mean_l;
			nm  = mean_l + dlt / cnt_l;
			if (nm > 64'sd2147483647)
				nm = 64'sd2147483647;
			if (nm < -64'sd2147483648)
				nm = -64'sd2147483648;
			st_mean = nm[MEAN_W-1:0];
			res = xq - nm;
			ma = (dlt < 0) ? -dlt : dlt;
			mb = (res < 0) ? -res : res;
			prod = ma * mb;
			term = prod >> TERM_SHIFT;
			// opposite signs only arise from truncation and add nothing
			if ((dlt < 0) != (res < 0))
				term = 0;
			sum_l = st_sum;
			room  = SUM_MAX - sum_l;
			sum_l = (term > room) ? SUM_MAX : sum_l + term;
			st_sum = sum_l[SUM_W-1:0];
		end
		cnt_l = st_count;
		sum_l = st_sum;
		if (st_count <= 1) begin
			vq = 0;
		end else begin
			d  = cnt_l - 1;
			q  = sum_l / d;
			rm = sum_l % d;
			if (q > (VAR_MAX >> VAR_UP))
				vq = VAR_MAX;
			else
				vq = (q << VAR_UP) + ((rm << VAR_UP) / d);
			if (vq > VAR_MAX)
				vq = VAR_MAX;
		end
		r.mean     = st_mean;
		r.variance = vq[VAR_W-1:0];
		r.count    = cnt_l[COUNT_OUT_W-1:0];
		return r;
	endfunction

	task automatic flag_error(input string msg);
		n_err++;
		if (n_err <= 10)
			$display("%s", msg);
	endtask

	task automatic push_sample(input int v, input bit rst, input bit drain);
		sample_item_t it;
		it.value   = v[SAMPLE_W-1:0];
		it.restart = rst;
		it.drain   = drain;
		sample_q.push_back(it);
		if (rst)
			shadow_cnt = 0;
		if (shadow_cnt < int'(CNT_FULL)) begin
			shadow_cnt++;
			n_real++;
		end
	endtask

	// input beats feed the predictor, output beats are checked against it
	always @(posedge clk) begin
		stats_t want;
		if (arst_n) begin
			cyc++;
			if (in_valid && !in_stall) begin
				stats_q.push_back(welford_update(sample, restart));
				n_taken++;
			end
			if (out_valid && !out_stall) begin
				if (stats_q.size() == 0) begin
					flag_error($sformatf("result beat %0d with nothing expected", n_results));
				end else begin
					want = stats_q.pop_front();
					if (mean_out !== want.mean)
						flag_error($sformatf("beat %0d mean_out: expected %h, got %h",
							n_results, want.mean, mean_out));
					if (variance_out !== want.variance)
						flag_error($sformatf("beat %0d variance_out: expected %h, got %h",
							n_results, want.variance, variance_out));
					if (count_out !== want.count)
						flag_error($sformatf("beat %0d count_out: expected %0d, got %0d",
							n_results, want.count, count_out));
					if (saturated !== want.sat)
						flag_error($sformatf("beat %0d saturated: expected %b, got %b",
							n_results, want.sat, saturated));
				end
				n_results++;
			end
		end
	end

	// sender: bursts with random gaps, holds a beat while stalled
	always @(negedge clk) begin
		sample_item_t it;
		bit           go;
		go = 1'b0;
		if (arst_n && !(in_valid && n_taken != n_sent)) begin
			if (gap_left != 0)
				gap_left--;
			else if (sample_q.size() != 0 && !(sample_q[0].drain && stats_q.size() != 0))
				go = 1'b1;
			if (go) begin
				it = sample_q.pop_front();
				sample   <= it.value;
				restart  <= it.restart;
				in_valid <= 1'b1;
				n_sent++;
				if (burst_left == 0) begin
					gap_left   = $urandom_range(1, MAX_GAP);
					burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
						: $urandom_range(0, 7);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
				sample   <= SAMPLE_W'($urandom);
				restart  <= 1'($urandom);
			end
		end
	end

	// receiver: alternating stall and free runs, now and then a long free stretch
	always @(negedge clk) begin
		if (rx_left != 0) begin
			rx_left--;
		end else if ($urandom_range(0, 4) == 0) begin
			out_stall <= 1'b0;
			rx_left = $urandom_range(200, 800);
		end else if (out_stall) begin
			out_stall <= 1'b0;
			rx_left = $urandom_range(1, 60);
		end else begin
			out_stall <= 1'b1;
			rx_left = $urandom_range(1, MAX_STALL);
		end
	end

	initial begin
		int v, centre, len, style, base;
		bit fresh, hold, first_seq;

		// directed: extremes, restarts, zero and tiny deltas
		push_sample(32767, 1'b0, 1'b0);
		push_sample(-32768, 1'b0, 1'b0);
		push_sample(0, 1'b0, 1'b0);
		push_sample(-1, 1'b0, 1'b0);
		push_sample(1, 1'b0, 1'b0);
		push_sample(32767, 1'b0, 1'b0);
		push_sample(-32768, 1'b0, 1'b0);
		push_sample(-32768, 1'b1, 1'b0);
		push_sample(-32768, 1'b0, 1'b0);
		push_sample(32767, 1'b0, 1'b0);
		push_sample(0, 1'b1, 1'b1);
		push_sample(0, 1'b1, 1'b0);
		push_sample(0, 1'b0, 1'b0);
		push_sample(0, 1'b0, 1'b0);
		push_sample(1, 1'b0, 1'b0);
		push_sample(-1, 1'b0, 1'b0);
		push_sample(12345, 1'b1, 1'b0);
		push_sample(12346, 1'b0, 1'b0);
		push_sample(-12345, 1'b0, 1'b0);
		push_sample(32767, 1'b1, 1'b0);
		push_sample(32767, 1'b0, 1'b0);
		push_sample(-32767, 1'b0, 1'b0);

		// random: mostly restarted sequences, some long enough to fill the count
		base = n_real;
		first_seq = 1'b1;
		while (n_real < base + RAND_ITEMS) begin
			if (first_seq || $urandom_range(0, 9) == 0)
				len = $urandom_range(240, 300);
			else
				len = $urandom_range(2, 40);
			style  = $urandom_range(0, 4);
			centre = $urandom_range(0, 65535) - 32768;
			fresh  = ($urandom_range(0, 7) != 0);
			hold   = first_seq || ($urandom_range(0, 9) == 0);
			first_seq = 1'b0;
			for (int k = 0; k < len; k++) begin
				case (style)
					0: begin
						v = $urandom_range(0, 65535) - 32768;
					end
					1: begin
						v = $urandom_range(0, 1) ? 32767 : -32768;
					end
					2: begin
						v = centre + int'($urandom_range(0, 64)) - 32;
						if (v > 32767)
							v = 32767;
						if (v < -32768)
							v = -32768;
					end
					3: begin
						v = centre;
					end
					default: begin
						v = int'($urandom_range(0, 16)) - 8;
					end
				endcase
				push_sample(v, (k == 0 && fresh) || $urandom_range(0, 59) == 0,
					k == 0 && hold);
			end
		end

		cyc_limit = 4 * longint'(sample_q.size()) * (BLK_CYC + MAX_GAP + MAX_STALL) + 10000;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (!(sample_q.size() == 0 && n_taken == n_sent && !in_valid
				&& stats_q.size() == 0) && cyc < cyc_limit)
			@(negedge clk);
		if (cyc < cyc_limit)
			repeat (DRAIN_CYC) @(negedge clk);

		if (cyc >= cyc_limit || n_err != 0 || stats_q.size() != 0)
			$display("FAIL welford_mean_variance");
		else
			$display("PASS welford_mean_variance");
		$finish;
	end

endmodule

@@ welford_mean_variance.f @@
src/wmv_pkg.sv
src/wmv_div.sv
src/welford_mean_variance.sv
sim/welford_mean_variance_tb.sv
